### src/positional_sequence_store_assert.svh
// ----------------------------------------------------------------------------
// positional_sequence_store_assert.svh
// Assertion macros for the positional sequence store. They expand to
// concurrent assertions in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_STORE_ASSERT_SVH
`define POSITIONAL_SEQUENCE_STORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside reset.
`define PSS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define PSS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define PSS_ASSERT(name, clk, rst_n, prop, msg)
`define PSS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)

`endif

`endif

### src/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Operation codes, status codes and cell command types shared by the
// positional sequence store and its cells.
// ----------------------------------------------------------------------------
package pss_pkg;

  // Request operations
  typedef enum logic [3:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_INSERT     = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_POP_FRONT  = 4'd4,
    OP_REMOVE     = 4'd5,
    OP_READ       = 4'd6,
    OP_WRITE      = 4'd7,
    OP_CLEAR      = 4'd8,
    OP_FRONT      = 4'd9,
    OP_BACK       = 4'd10
  } op_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // What each cell does with the broadcast position
  typedef enum logic [1:0] {
    CK_HOLD   = 2'd0,
    CK_INSERT = 2'd1,
    CK_REMOVE = 2'd2,
    CK_WRITE  = 2'd3
  } cell_kind_e;

  // Command broadcast along the cell row
  typedef struct packed {
    cell_kind_e kind;
    logic       rd_en;
  } cell_ctl_t;

  // Cells merged per register of the read gather tree
  localparam int GatherGroup = 32;

endpackage

### src/positional_sequence_store.sv
// ----------------------------------------------------------------------------
// positional_sequence_store
// Ordered sequence of up to CAPACITY words held packed in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (operation, position, item_value) enters on the input
//   channel; each request gives exactly one result word (read_value, status,
//   element_count, is_empty) on the output channel, in request order.
//   Insertions shift later cells up and removals shift them down, all cells
//   moving in the same cycle.
//   After acceptance a request passes through the cell update, the group
//   gather and the final merge into the output register, in that order.
//   No new request is taken while one is in flight: the input stays closed
//   from acceptance until its result is loaded into the output register.
//   The output register holds a finished result while the receiver stalls;
//   the next request is still taken and runs up to the final merge, where it
//   waits until the output register is free, with the input closed meanwhile.
//   Reset empties the store (count zero); cell contents are not cleared and
//   are only ever read below the count.
// ----------------------------------------------------------------------------
`include "positional_sequence_store_assert.svh"

module positional_sequence_store
  import pss_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [3:0]                          operation_i,
  input  logic [$clog2(CAPACITY+1)-1:0]       position_i,
  input  logic [DATA_WIDTH-1:0]               item_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [DATA_WIDTH-1:0]               read_value_o,
  output logic [1:0]                          status_o,
  output logic [$clog2(CAPACITY+1)-1:0]       element_count_o,
  output logic                                is_empty_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_GATHER = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  cell_ctl_t             ctl_q, ctl_d;
  logic [CNT_W-1:0]      at_q, at_d;
  logic [DATA_WIDTH-1:0] val_q;
  status_e               st_q, st_d;

  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] read_value_q;
  status_e               status_q;
  logic [CNT_W-1:0]      element_count_q;
  logic                  is_empty_q;

  logic                  in_acc;
  logic                  out_load;
  logic                  full, empty;
  logic [DATA_WIDTH-1:0] cell_val [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd  [CAPACITY];
  logic [DATA_WIDTH-1:0] gather_rd;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign full       = (count_q >= CapCount);
  assign empty      = (count_q == '0);

  // Decode a request against the current count
  always_comb begin
    ctl_d   = '{kind: CK_HOLD, rd_en: 1'b0};
    at_d    = position_i;
    st_d    = ST_OK;
    count_d = count_q;
    case (op_e'(operation_i))
      OP_PUSH_BACK: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          ctl_d.kind = CK_INSERT;
          at_d       = count_q;
          count_d    = count_q + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          ctl_d.kind = CK_INSERT;
          at_d       = '0;
          count_d    = count_q + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (position_i > count_q) begin
          st_d = ST_RANGE;
        end else if (full) begin
          st_d = ST_FULL;
        end else begin
          ctl_d.kind = CK_INSERT;
          count_d    = count_q + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          ctl_d.kind = CK_REMOVE;
          at_d       = '0;
          count_d    = count_q - CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (position_i >= count_q) begin
          st_d = ST_RANGE;
        end else begin
          ctl_d.kind = CK_REMOVE;
          count_d    = count_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (position_i >= count_q) begin
          st_d = ST_RANGE;
        end else begin
          ctl_d.rd_en = 1'b1;
        end
      end
      OP_WRITE: begin
        if (position_i >= count_q) begin
          st_d = ST_RANGE;
        end else begin
          ctl_d.kind = CK_WRITE;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      OP_FRONT: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          ctl_d.rd_en = 1'b1;
          at_d        = '0;
        end
      end
      OP_BACK: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          ctl_d.rd_en = 1'b1;
          at_d        = count_q - CNT_W'(1);
        end
      end
      default: st_d = ST_OK;
    endcase
  end

  // Sequence one request through the row and the gather tree
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_EXEC;
      S_EXEC:   state_d = S_GATHER;
      S_GATHER: state_d = S_DONE;
      S_DONE:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ctl_q       <= '{kind: CK_HOLD, rd_en: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        count_q <= count_d;
        ctl_q   <= ctl_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the decoded request payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      at_q  <= at_d;
      val_q <= item_value_i;
      st_q  <= st_d;
    end
  end

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_val[i+1];
    end

    pss_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (state_q == S_EXEC),
      .ctl_i   (ctl_q),
      .at_i    (at_q),
      .value_i (val_q),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_val[i]),
      .rd_o    (cell_rd[i])
    );
  end

  pss_gather #(
    .DATA_WIDTH (DATA_WIDTH),
    .CAPACITY   (CAPACITY)
  ) u_gather (
    .clk_i (clk_i),
    .rd_i  (cell_rd),
    .rd_o  (gather_rd)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_value_q    <= gather_rd;
      status_q        <= st_q;
      element_count_q <= count_q;
      is_empty_q      <= (count_q == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_value_o    = read_value_q;
  assign status_o        = status_q;
  assign element_count_o = element_count_q;
  assign is_empty_o      = is_empty_q;

  // Checks
  `PSS_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CapCount,
              "count above capacity")
  `PSS_ASSERT(a_empty_matches_count, clk_i, rst_ni,
              !out_valid_o || (is_empty_o == (element_count_o == '0)),
              "empty flag disagrees with count")
  `PSS_ASSERT(a_fail_reads_zero, clk_i, rst_ni,
              !out_valid_o || (status_o == ST_OK) || (read_value_o == '0),
              "failed request returned data")
  `PSS_ASSERT_NEXT(a_full_push_holds, clk_i, rst_ni,
                   in_acc && full && (operation_i == OP_PUSH_BACK),
                   count_q == $past(count_q), "push when full changed count")

endmodule

### src/pss_cell.sv
// ----------------------------------------------------------------------------
// pss_cell
// One storage cell of the row. Takes its lower or upper neighbor on insert or
// remove, loads the new word on a match, and offers its word on a read match.
// ----------------------------------------------------------------------------
module pss_cell
  import pss_pkg::*;
#(
  parameter int DATA_WIDTH = 8,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  cell_ctl_t             ctl_i,
  input  logic [CNT_W-1:0]      at_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] lower_i,
  input  logic [DATA_WIDTH-1:0] upper_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] rd_q;

  // Pick the next word for this cell
  always_comb begin
    data_d = data_q;
    case (ctl_i.kind)
      CK_INSERT: begin
        if (MyIdx > at_i) begin
          data_d = lower_i;
        end else if (MyIdx == at_i) begin
          data_d = value_i;
        end
      end
      CK_REMOVE: begin
        if (MyIdx >= at_i) begin
          data_d = upper_i;
        end
      end
      CK_WRITE: begin
        if (MyIdx == at_i) begin
          data_d = value_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Advance the cell on an execute strobe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  // Offer the word when this cell is the one read
  always_ff @(posedge clk_i) begin
    rd_q <= (ctl_i.rd_en && (MyIdx == at_i)) ? data_q : '0;
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

### src/pss_gather.sv
// ----------------------------------------------------------------------------
// pss_gather
// Collects the read word from the cell row: one register per group of cells,
// then a final merge of the group registers.
// ----------------------------------------------------------------------------
module pss_gather
  import pss_pkg::*;
#(
  parameter int DATA_WIDTH = 8,
  parameter int CAPACITY   = 64
) (
  input  logic                  clk_i,
  input  logic [DATA_WIDTH-1:0] rd_i [CAPACITY],
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam int NumGroups = (CAPACITY + GatherGroup - 1) / GatherGroup;

  logic [DATA_WIDTH-1:0] grp_q [NumGroups];

  // Merge each group of cells into its register
  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    localparam int Base = g * GatherGroup;
    localparam int Size = ((CAPACITY - Base) < GatherGroup) ? (CAPACITY - Base) : GatherGroup;
    logic [DATA_WIDTH-1:0] grp_d;

    always_comb begin
      grp_d = '0;
      for (int k = 0; k < Size; k++) begin
        grp_d = grp_d | rd_i[Base + k];
      end
    end

    always_ff @(posedge clk_i) begin
      grp_q[g] <= grp_d;
    end
  end

  // Merge the group registers
  always_comb begin
    rd_o = '0;
    for (int g = 0; g < NumGroups; g++) begin
      rd_o = rd_o | grp_q[g];
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives request words into the positional sequence store and checks every
// result word against a shadow copy of the sequence in the testbench or against
// the result given in a directed row. A short table of directed requests comes
// first. Random traffic follows in four phases with different sender and
// receiver idling. Each phase mixes fill, balanced, drain and noise bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pss_pkg::*;

  localparam int StoreDepth = 64;
  localparam int HoldCycles = 60;
  localparam int SettleCycles = 8;
  localparam logic [3:0] OpUnusedLow = 4'd11;
  localparam logic [3:0] OpUnusedHigh = 4'd15;

  // One result word as the block reports it
  typedef struct packed {
    logic [7:0] rd;
    status_e    st;
    logic [6:0] cnt;
    logic       empty;
  } outcome_t;

  // One row of the directed table
  typedef struct packed {
    logic [3:0] op;
    logic [6:0] pos;
    logic [7:0] val;
    logic       typed;
    outcome_t   res;
  } directed_row_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN,
    MIX_NOISE
  } traffic_mix_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [3:0] operation_i = '0;
  logic [6:0] position_i = '0;
  logic [7:0] item_value_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] read_value_o;
  logic [1:0] status_o;
  logic [6:0] element_count_o;
  logic       is_empty_o;

  // Shadow copy of the sequence
  logic [7:0] shadow_cells [0:StoreDepth-1];
  int         shadow_count = 0;

  outcome_t   awaited_replies [$];
  logic       row_typed = 1'b0;
  outcome_t   row_result = '0;
  int         mismatch_count = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         hold_requests = 0;

  directed_row_t directed_rows [0:24] = '{
    '{OP_POP_BACK,   7'd0,   8'd0,   1'b1, '{8'd0, ST_EMPTY, 7'd0, 1'b1}},
    '{OP_POP_FRONT,  7'd0,   8'd0,   1'b1, '{8'd0, ST_EMPTY, 7'd0, 1'b1}},
    '{OP_FRONT,      7'd0,   8'd0,   1'b1, '{8'd0, ST_EMPTY, 7'd0, 1'b1}},
    '{OP_BACK,       7'd0,   8'd0,   1'b1, '{8'd0, ST_EMPTY, 7'd0, 1'b1}},
    '{OP_READ,       7'd0,   8'd0,   1'b1, '{8'd0, ST_RANGE, 7'd0, 1'b1}},
    '{OP_REMOVE,     7'd127, 8'd0,   1'b1, '{8'd0, ST_RANGE, 7'd0, 1'b1}},
    '{OP_WRITE,      7'd0,   8'd255, 1'b1, '{8'd0, ST_RANGE, 7'd0, 1'b1}},
    '{OP_INSERT,     7'd1,   8'd255, 1'b1, '{8'd0, ST_RANGE, 7'd0, 1'b1}},
    '{OP_INSERT,     7'd0,   8'd255, 1'b1, '{8'd0, ST_OK,    7'd1, 1'b0}},
    '{OP_PUSH_BACK,  7'd0,   8'd0,   1'b1, '{8'd0, ST_OK,    7'd2, 1'b0}},
    '{OP_PUSH_FRONT, 7'd127, 8'hA5,  1'b1, '{8'd0, ST_OK,    7'd3, 1'b0}},
    '{OP_INSERT,     7'd3,   8'h5A,  1'b1, '{8'd0, ST_OK,    7'd4, 1'b0}},
    '{OP_READ,       7'd1,   8'd0,   1'b0, '0},
    '{OP_WRITE,      7'd2,   8'h81,  1'b0, '0},
    '{OP_READ,       7'd4,   8'd0,   1'b0, '0},
    '{OP_FRONT,      7'd0,   8'd0,   1'b0, '0},
    '{OP_BACK,       7'd0,   8'd0,   1'b0, '0},
    '{OP_INSERT,     7'd5,   8'd7,   1'b0, '0},
    '{OP_REMOVE,     7'd1,   8'd0,   1'b0, '0},
    '{OP_POP_FRONT,  7'd0,   8'd0,   1'b0, '0},
    '{OP_POP_BACK,   7'd0,   8'd0,   1'b0, '0},
    '{OpUnusedLow,   7'd64,  8'hC3,  1'b0, '0},
    '{OpUnusedHigh,  7'd127, 8'd255, 1'b0, '0},
    '{OP_CLEAR,      7'd0,   8'd0,   1'b1, '{8'd0, ST_OK,    7'd0, 1'b1}},
    '{OP_PUSH_BACK,  7'd0,   8'd255, 1'b1, '{8'd0, ST_OK,    7'd1, 1'b0}}
  };

  positional_sequence_store #(
    .CAPACITY  (StoreDepth),
    .DATA_WIDTH(8)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_o   (read_value_o),
    .status_o       (status_o),
    .element_count_o(element_count_o),
    .is_empty_o     (is_empty_o)
  );

  // Free-running clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shift later cells up and place the new value
  function automatic void open_gap(input int at, input logic [7:0] v);
    for (int i = shadow_count; i > at; i--) shadow_cells[i] = shadow_cells[i-1];
    shadow_cells[at] = v;
    shadow_count++;
  endfunction

  // Shift later cells down over the removed one
  function automatic void close_gap(input int at);
    for (int i = at; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
    shadow_count--;
  endfunction

  // Apply one request to the shadow sequence and return its result word
  function automatic outcome_t apply_request(input logic [3:0] op, input logic [6:0] pos,
                                             input logic [7:0] val);
    outcome_t r;
    logic     full;
    r = '0;
    full = (shadow_count >= StoreDepth);
    case (op)
      OP_PUSH_BACK: begin
        if (full) r.st = ST_FULL;
        else open_gap(shadow_count, val);
      end
      OP_PUSH_FRONT: begin
        if (full) r.st = ST_FULL;
        else open_gap(0, val);
      end
      OP_INSERT: begin
        if (pos > shadow_count) r.st = ST_RANGE;
        else if (full) r.st = ST_FULL;
        else open_gap(pos, val);
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) r.st = ST_EMPTY;
        else shadow_count--;
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) r.st = ST_EMPTY;
        else close_gap(0);
      end
      OP_REMOVE: begin
        if (pos >= shadow_count) r.st = ST_RANGE;
        else close_gap(pos);
      end
      OP_READ: begin
        if (pos >= shadow_count) r.st = ST_RANGE;
        else r.rd = shadow_cells[pos];
      end
      OP_WRITE: begin
        if (pos >= shadow_count) r.st = ST_RANGE;
        else shadow_cells[pos] = val;
      end
      OP_CLEAR: shadow_count = 0;
      OP_FRONT: begin
        if (shadow_count == 0) r.st = ST_EMPTY;
        else r.rd = shadow_cells[0];
      end
      OP_BACK: begin
        if (shadow_count == 0) r.st = ST_EMPTY;
        else r.rd = shadow_cells[shadow_count-1];
      end
      default: ;
    endcase
    r.cnt = shadow_count[6:0];
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
    mismatch_count++;
  endtask

  // Compare one result word field by field
  task automatic check_reply(input outcome_t exp);
    if (read_value_o !== exp.rd) report_mismatch("read_value", read_value_o, exp.rd);
    if (status_o !== exp.st) report_mismatch("status", status_o, exp.st);
    if (element_count_o !== exp.cnt) report_mismatch("element_count", element_count_o, exp.cnt);
    if (is_empty_o !== exp.empty) report_mismatch("is_empty", is_empty_o, exp.empty);
  endtask

  // Predict on every accepted request, check every accepted result
  always @(posedge clk_i) begin : reply_checker
    outcome_t predicted;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predicted = apply_request(operation_i, position_i, item_value_i);
      awaited_replies = {awaited_replies, (row_typed ? row_result : predicted)};
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected word, status", status_o, 0);
      end else begin
        check_reply(awaited_replies[0]);
        awaited_replies.delete(0);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int holds_served;
    int held;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        for (held = 0; held < HoldCycles; held++) begin
          out_ready_i <= 1'b0;
          @(negedge clk_i);
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Drop valid for a random number of cycles; call at a falling edge
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Present one word at a falling edge and hold it until accepted
  task automatic present_word(input logic [3:0] op, input logic [6:0] pos,
                              input logic [7:0] val, input logic typed,
                              input outcome_t res);
    in_valid_i <= 1'b1;
    operation_i <= op;
    position_i <= pos;
    item_value_i <= val;
    row_typed = typed;
    row_result = res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Build and send one random request shaped by the traffic mix
  task automatic send_random(input traffic_mix_e mix);
    logic [3:0] op;
    logic [6:0] pos;
    int         r;
    @(negedge clk_i);
    idle_gap();
    r = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (r < 40) op = OP_PUSH_BACK;
        else if (r < 60) op = OP_PUSH_FRONT;
        else if (r < 85) op = OP_INSERT;
        else if (r < 93) op = OP_READ;
        else if (r < 97) op = OP_WRITE;
        else op = OP_BACK;
      end
      MIX_DRAIN: begin
        if (r < 25) op = OP_POP_BACK;
        else if (r < 50) op = OP_POP_FRONT;
        else if (r < 75) op = OP_REMOVE;
        else if (r < 85) op = OP_READ;
        else if (r < 92) op = OP_FRONT;
        else op = OP_BACK;
      end
      MIX_BALANCED: begin
        op = 4'($urandom_range(OP_PUSH_BACK, OP_BACK));
        // keep clears rare so the sequence can grow
        if (op == OP_CLEAR && $urandom_range(9) != 0) op = OP_WRITE;
      end
      default: op = 4'($urandom_range(0, 15));
    endcase
    if (mix == MIX_NOISE || $urandom_range(99) < 20) pos = 7'($urandom_range(0, 127));
    else pos = 7'($urandom_range(0, shadow_count));
    present_word(op, pos, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Pause the sender until every awaited result has come
  task automatic wait_for_replies();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int            phase_idle [0:3];
    int            phase_stall [0:3];
    int            burst_len [0:3];
    traffic_mix_e  burst_mix [0:3];
    phase_idle = '{0, 57, 0, 20};
    phase_stall = '{0, 0, 57, 20};
    burst_mix = '{MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_NOISE};
    burst_len = '{90, 60, 80, 35};

    // Hold reset, then release it
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < 25; i++) begin
      @(negedge clk_i);
      present_word(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].res);
    end
    wait_for_replies();

    // Random traffic, one idling setting per phase
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      // fill the pipeline against a stalled receiver
      if (p == 0) hold_requests++;
      for (int b = 0; b < 4; b++) begin
        for (int n = 0; n < burst_len[b]; n++) send_random(burst_mix[b]);
      end
      wait_for_replies();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
